// File: rtl/lrc_pkg.sv
// Shared types and constants of the lidar ray cast unit.
`timescale 1ns / 1ps
package lrc_pkg;

    localparam int CORDIC_STEPS = 24;
    localparam int STEP_BITS    = 5;
    localparam int CORDIC_BITS  = 34;
    localparam int DIR_BITS     = 16;
    localparam int RANGE_BITS   = 15;
    localparam int NOISE_BITS   = 10;
    localparam int COUNT_BITS   = 7;
    localparam int INDEX_BITS   = 6;
    localparam int FRAC_BITS    = 14;
    localparam int QUOT_BITS    = 15;
    localparam int DIV_CNT_BITS = 4;
    localparam int QUEUE_DEPTH  = 2;

    localparam logic signed [CORDIC_BITS-1:0] CORDIC_X_INIT = 34'sd652032874;
    localparam logic signed [DIR_BITS-1:0]    DIR_ONE       = 16'sd16384;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_CAST  = 1'b1;

    typedef logic [1:0] reg_index_t;
    localparam reg_index_t REG_WALL_COUNT = 2'd0;
    localparam reg_index_t REG_NEAR_LIMIT = 2'd1;
    localparam reg_index_t REG_FAR_LIMIT  = 2'd2;

    localparam logic [COUNT_BITS-1:0] WALL_COUNT_RESET = 7'd0;
    localparam logic [RANGE_BITS-1:0] NEAR_LIMIT_RESET = 15'd31;
    localparam logic [RANGE_BITS-1:0] FAR_LIMIT_RESET  = 15'd3584;

    typedef struct packed {
        logic [COUNT_BITS-1:0] wall_count;
        logic [RANGE_BITS-1:0] near_limit;
        logic [RANGE_BITS-1:0] far_limit;
    } lrc_cfg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CORDIC,
        ST_READ,
        ST_SUB,
        ST_MUL,
        ST_DIFF,
        ST_CMP1,
        ST_CMP2,
        ST_DIV,
        ST_DONE
    } back_state_t;

    // Arctangent of 2^-i as a fraction of a full turn in a 32-bit phase.
    function automatic logic signed [CORDIC_BITS-1:0] cordic_atan(input logic [STEP_BITS-1:0] i);
        logic signed [CORDIC_BITS-1:0] a;
        begin
            unique case (i)
                5'd0:    a = 34'sh20000000;
                5'd1:    a = 34'sh12E4051D;
                5'd2:    a = 34'sh09FB385B;
                5'd3:    a = 34'sh051111D4;
                5'd4:    a = 34'sh028B0D43;
                5'd5:    a = 34'sh0145D7E1;
                5'd6:    a = 34'sh00A2F61E;
                5'd7:    a = 34'sh00517C55;
                5'd8:    a = 34'sh0028BE53;
                5'd9:    a = 34'sh00145F2E;
                5'd10:   a = 34'sh000A2F98;
                5'd11:   a = 34'sh000517CC;
                5'd12:   a = 34'sh00028BE6;
                5'd13:   a = 34'sh000145F3;
                5'd14:   a = 34'sh0000A2F9;
                5'd15:   a = 34'sh0000517C;
                5'd16:   a = 34'sh000028BE;
                5'd17:   a = 34'sh0000145F;
                5'd18:   a = 34'sh00000A2F;
                5'd19:   a = 34'sh00000517;
                5'd20:   a = 34'sh0000028B;
                5'd21:   a = 34'sh00000145;
                5'd22:   a = 34'sh000000A2;
                5'd23:   a = 34'sh00000051;
                default: a = '0;
            endcase
            return a;
        end
    endfunction

endpackage

// File: rtl/lrc_channels.sv
// Handshake channels of the lidar ray cast unit: command, result and configuration.
`timescale 1ns / 1ps
interface lrc_cmd_if #(
    parameter int COORD_BITS = 16,
    parameter int ANGLE_BITS = 12
);
    logic                         valid;
    logic                         ready;
    logic                         command;
    logic [5:0]                   wall_index;
    logic signed [COORD_BITS-1:0] start_x;
    logic signed [COORD_BITS-1:0] start_y;
    logic signed [COORD_BITS-1:0] end_x;
    logic signed [COORD_BITS-1:0] end_y;
    logic signed [COORD_BITS-1:0] origin_x;
    logic signed [COORD_BITS-1:0] origin_y;
    logic [ANGLE_BITS-1:0]        angle;
    logic signed [9:0]            noise;

    modport source (output valid, command, wall_index, start_x, start_y, end_x, end_y,
                     origin_x, origin_y, angle, noise, input ready);
    modport sink (input valid, command, wall_index, start_x, start_y, end_x, end_y,
                   origin_x, origin_y, angle, noise, output ready);
endinterface

interface lrc_res_if;
    logic        valid;
    logic        ready;
    logic [14:0] range;
    logic        hit;

    modport source (output valid, range, hit, input ready);
    modport sink (input valid, range, hit, output ready);
endinterface

interface lrc_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [14:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/lrc_front.sv
// Front end: accepts command words, drops writes beyond the table, queues the rest.
`timescale 1ns / 1ps
module lrc_front #(
    parameter int MAX_WALLS  = 64,
    parameter int COORD_BITS = 16,
    parameter int ANGLE_BITS = 12
) (
    input  logic clk,
    input  logic rst_n,
    lrc_cmd_if.sink   cmd,
    lrc_cmd_if.source q_out
);
    import lrc_pkg::*;

    typedef struct packed {
        logic                         command;
        logic [INDEX_BITS-1:0]        wall_index;
        logic signed [COORD_BITS-1:0] start_x;
        logic signed [COORD_BITS-1:0] start_y;
        logic signed [COORD_BITS-1:0] end_x;
        logic signed [COORD_BITS-1:0] end_y;
        logic signed [COORD_BITS-1:0] origin_x;
        logic signed [COORD_BITS-1:0] origin_y;
        logic [ANGLE_BITS-1:0]        angle;
        logic signed [NOISE_BITS-1:0] noise;
    } queue_word_t;

    queue_word_t slot_reg [QUEUE_DEPTH];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;
    logic        take, keep, pop;
    queue_word_t in_word, head;

    assign cmd.ready = (count_reg != 2'(QUEUE_DEPTH));
    assign take      = cmd.valid && cmd.ready;
    // A write aimed past the end of the table is taken and discarded here.
    assign keep      = take && ((cmd.command == CMD_CAST) ||
                                (32'(cmd.wall_index) < MAX_WALLS));
    assign pop       = q_out.valid && q_out.ready;

    assign in_word = '{command: cmd.command, wall_index: cmd.wall_index,
                       start_x: cmd.start_x, start_y: cmd.start_y,
                       end_x: cmd.end_x, end_y: cmd.end_y,
                       origin_x: cmd.origin_x, origin_y: cmd.origin_y,
                       angle: cmd.angle, noise: cmd.noise};

    always_comb
    begin
        wr_ptr_next = keep ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(keep) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (keep)
        begin
            slot_reg[wr_ptr_reg] <= in_word;
        end
    end

    assign head             = slot_reg[rd_ptr_reg];
    assign q_out.valid      = (count_reg != 2'd0);
    assign q_out.command    = head.command;
    assign q_out.wall_index = head.wall_index;
    assign q_out.start_x    = head.start_x;
    assign q_out.start_y    = head.start_y;
    assign q_out.end_x      = head.end_x;
    assign q_out.end_y      = head.end_y;
    assign q_out.origin_x   = head.origin_x;
    assign q_out.origin_y   = head.origin_y;
    assign q_out.angle      = head.angle;
    assign q_out.noise      = head.noise;

endmodule

// File: rtl/lrc_back.sv
// Back end: wall table, direction CORDIC, per-wall intersection test, divider and clamp.
`timescale 1ns / 1ps
module lrc_back #(
    parameter int MAX_WALLS  = 64,
    parameter int COORD_BITS = 16,
    parameter int ANGLE_BITS = 12
) (
    input  logic clk,
    input  logic rst_n,
    lrc_cmd_if.sink   q_in,
    lrc_res_if.source res,
    input  lrc_pkg::lrc_cfg_t cfg
);
    import lrc_pkg::*;

    localparam int AW   = (MAX_WALLS > 1) ? $clog2(MAX_WALLS) : 1;
    localparam int KW   = $clog2(MAX_WALLS + 1);
    localparam int DW   = (COORD_BITS + 1 > DIR_BITS) ? COORD_BITS + 1 : DIR_BITS;
    localparam int PW   = 2 * DW;
    localparam int SW   = PW + 1;
    localparam int CRW  = SW - 1;
    localparam int H    = CRW / 2;
    localparam int CMPW = CRW + RANGE_BITS + 2;
    localparam int EW   = 4 * COORD_BITS;

    function automatic logic signed [DIR_BITS-1:0] to_q14(input logic signed [CORDIC_BITS-1:0] v);
        logic signed [CORDIC_BITS-1:0] t;
        logic signed [DIR_BITS-1:0]    r;
        begin
            t = (v + 34'sd32768) >>> 16;
            if (t > CORDIC_BITS'(DIR_ONE))
                r = DIR_ONE;
            else if (t < -CORDIC_BITS'(DIR_ONE))
                r = -DIR_ONE;
            else
                r = DIR_BITS'(t);
            return r;
        end
    endfunction

    back_state_t state_reg, state_next;

    // Control
    logic [STEP_BITS-1:0]    step_reg;
    logic [KW-1:0]           k_reg;
    logic [DIV_CNT_BITS-1:0] div_cnt_reg;
    logic                    res_valid_reg;

    // Payload
    logic [EW-1:0]                  mem [MAX_WALLS];
    logic [EW-1:0]                  rd_reg;
    logic signed [COORD_BITS-1:0]   org_x_reg, org_y_reg;
    logic signed [NOISE_BITS-1:0]   noise_reg;
    logic [1:0]                     quad_reg;
    logic signed [CORDIC_BITS-1:0]  x_reg, y_reg, z_reg;
    logic signed [DIR_BITS-1:0]     dx_reg, dy_reg;
    logic signed [DW-1:0]           ex_reg, ey_reg, ox_reg, oy_reg;
    logic signed [PW-1:0]           p_dxey_reg, p_dyex_reg, p_oxey_reg;
    logic signed [PW-1:0]           p_oyex_reg, p_oxdy_reg, p_oydx_reg;
    logic [CRW-1:0]                 cr_reg, num_reg;
    logic [RANGE_BITS+H-1:0]        pp_lo_reg;
    logic [RANGE_BITS+CRW-H-1:0]    pp_hi_reg;
    logic [CRW-1:0]                 rem_reg;
    logic [FRAC_BITS:0]             low_reg;
    logic [QUOT_BITS-1:0]           quot_reg;
    logic [RANGE_BITS-1:0]          best_reg;
    logic [RANGE_BITS-1:0]          range_reg;
    logic                           hit_reg;

    // Combinational
    logic                           pop, mem_we, done_fire, last_step, last_wall, last_div;
    logic                           cand_ok, closer;
    logic [KW-1:0]                  n_wall;
    logic [AW-1:0]                  wr_addr;
    logic [31:0]                    phase, phase_rot, rr;
    logic [1:0]                     quad;
    logic signed [CORDIC_BITS-1:0]  xs, ys, atn;
    logic signed [DIR_BITS-1:0]     c_q14, s_q14;
    logic signed [SW-1:0]           cr_s, num_s, un_s;
    logic signed [SW-1:0]           cr_n, num_n, un_n;
    logic [CMPW-1:0]                lhs, rhs;
    logic [CRW:0]                   trial;
    logic signed [DW-1:0]           w_sx, w_sy, w_ex, w_ey, dx_w, dy_w;
    logic signed [RANGE_BITS+1:0]   sum_r, clamp_lo;

    assign n_wall  = (32'(cfg.wall_count) > MAX_WALLS) ? KW'(MAX_WALLS) : KW'(cfg.wall_count);
    assign wr_addr = AW'(q_in.wall_index);

    // Phase folding to within an eighth turn of an axis.
    assign phase     = 32'(q_in.angle) << (32 - ANGLE_BITS);
    assign phase_rot = phase + 32'h2000_0000;
    assign quad      = phase_rot[31:30];
    assign rr        = phase - {quad, 30'd0};

    assign xs  = x_reg >>> step_reg;
    assign ys  = y_reg >>> step_reg;
    assign atn = cordic_atan(step_reg);
    assign c_q14 = to_q14(x_reg);
    assign s_q14 = to_q14(y_reg);

    assign w_sx = DW'(signed'(rd_reg[EW-1 -: COORD_BITS]));
    assign w_sy = DW'(signed'(rd_reg[3*COORD_BITS-1 -: COORD_BITS]));
    assign w_ex = DW'(signed'(rd_reg[2*COORD_BITS-1 -: COORD_BITS]));
    assign w_ey = DW'(signed'(rd_reg[COORD_BITS-1:0]));
    assign dx_w = DW'(dx_reg);
    assign dy_w = DW'(dy_reg);

    // The sign of the cross product is folded into the numerators.
    always_comb
    begin
        cr_s  = SW'(p_dxey_reg) - SW'(p_dyex_reg);
        num_s = SW'(p_oxey_reg) - SW'(p_oyex_reg);
        un_s  = SW'(p_oxdy_reg) - SW'(p_oydx_reg);
        if (cr_s < 0)
        begin
            cr_n  = -cr_s;
            num_n = -num_s;
            un_n  = -un_s;
        end
        else
        begin
            cr_n  = cr_s;
            num_n = num_s;
            un_n  = un_s;
        end
        cand_ok = (cr_s != 0) && (num_n >= 0) && (un_n >= 0) && (un_n <= cr_n);
    end

    // The floored distance beats best exactly when num * 2^14 < best * cr.
    assign lhs    = CMPW'({num_reg, {FRAC_BITS{1'b0}}});
    assign rhs    = CMPW'(pp_lo_reg) + (CMPW'(pp_hi_reg) << H);
    assign closer = lhs < rhs;
    assign trial  = {rem_reg, low_reg[FRAC_BITS]};

    // The sum may be negative, so the lower clamp compares signed.
    assign sum_r    = (RANGE_BITS+2)'(best_reg) + (RANGE_BITS+2)'(noise_reg);
    assign clamp_lo = (sum_r < $signed((RANGE_BITS+2)'(cfg.near_limit))) ?
                      $signed((RANGE_BITS+2)'(cfg.near_limit)) : sum_r;

    assign last_step = (step_reg == STEP_BITS'(CORDIC_STEPS - 1));
    assign last_wall = (k_reg + KW'(1) >= n_wall);
    assign last_div  = (div_cnt_reg == DIV_CNT_BITS'(QUOT_BITS - 1));

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_in.valid && (q_in.command == CMD_CAST))
                    state_next = ST_CORDIC;
            end
            ST_CORDIC:
            begin
                if (last_step)
                    state_next = (n_wall == '0) ? ST_DONE : ST_READ;
            end
            ST_READ: state_next = ST_SUB;
            ST_SUB:  state_next = ST_MUL;
            ST_MUL:  state_next = ST_DIFF;
            ST_DIFF:
            begin
                if (cand_ok)
                    state_next = ST_CMP1;
                else
                    state_next = last_wall ? ST_DONE : ST_READ;
            end
            ST_CMP1: state_next = ST_CMP2;
            ST_CMP2:
            begin
                if (closer)
                    state_next = ST_DIV;
                else
                    state_next = last_wall ? ST_DONE : ST_READ;
            end
            ST_DIV:
            begin
                if (last_div)
                    state_next = last_wall ? ST_DONE : ST_READ;
            end
            ST_DONE:
            begin
                if (!res_valid_reg || res.ready)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs of the sequencer
    always_comb
    begin
        pop       = (state_reg == ST_IDLE) && q_in.valid;
        mem_we    = pop && (q_in.command == CMD_WRITE);
        done_fire = (state_reg == ST_DONE) && (!res_valid_reg || res.ready);
    end

    assign q_in.ready = (state_reg == ST_IDLE);
    assign res.valid  = res_valid_reg;
    assign res.range  = range_reg;
    assign res.hit    = hit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            k_reg         <= '0;
            div_cnt_reg   <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CORDIC)
                step_reg <= step_reg + STEP_BITS'(1);
            else
                step_reg <= '0;
            if (state_reg == ST_CORDIC)
                k_reg <= '0;
            else if ((state_next == ST_READ) && (state_reg != ST_CORDIC))
                k_reg <= k_reg + KW'(1);
            if (state_reg == ST_DIV)
                div_cnt_reg <= div_cnt_reg + DIV_CNT_BITS'(1);
            else
                div_cnt_reg <= '0;
            if (done_fire)
                res_valid_reg <= 1'b1;
            else if (res.ready)
                res_valid_reg <= 1'b0;
        end
    end

    // Wall table, one write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[wr_addr] <= {q_in.start_x, q_in.start_y, q_in.end_x, q_in.end_y};
        rd_reg <= mem[k_reg[AW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            org_x_reg <= q_in.origin_x;
            org_y_reg <= q_in.origin_y;
            noise_reg <= q_in.noise;
            quad_reg  <= quad;
            x_reg     <= CORDIC_X_INIT;
            y_reg     <= '0;
            z_reg     <= CORDIC_BITS'(signed'(rr));
            best_reg  <= cfg.far_limit;
        end
        if (state_reg == ST_CORDIC)
        begin
            if (!z_reg[CORDIC_BITS-1])
            begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - atn;
            end
            else
            begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + atn;
            end
        end
        if (state_reg == ST_READ)
        begin
            unique case (quad_reg)
                2'd0:
                begin
                    dx_reg <= c_q14;
                    dy_reg <= s_q14;
                end
                2'd1:
                begin
                    dx_reg <= -s_q14;
                    dy_reg <= c_q14;
                end
                2'd2:
                begin
                    dx_reg <= -c_q14;
                    dy_reg <= -s_q14;
                end
                default:
                begin
                    dx_reg <= s_q14;
                    dy_reg <= -c_q14;
                end
            endcase
        end
        if (state_reg == ST_SUB)
        begin
            ex_reg <= w_ex - w_sx;
            ey_reg <= w_ey - w_sy;
            ox_reg <= w_sx - DW'(org_x_reg);
            oy_reg <= w_sy - DW'(org_y_reg);
        end
        if (state_reg == ST_MUL)
        begin
            p_dxey_reg <= dx_w * ey_reg;
            p_dyex_reg <= dy_w * ex_reg;
            p_oxey_reg <= ox_reg * ey_reg;
            p_oyex_reg <= oy_reg * ex_reg;
            p_oxdy_reg <= ox_reg * dy_w;
            p_oydx_reg <= oy_reg * dx_w;
        end
        if (state_reg == ST_DIFF)
        begin
            cr_reg  <= CRW'(cr_n);
            num_reg <= CRW'(num_n);
        end
        if (state_reg == ST_CMP1)
        begin
            pp_lo_reg <= (RANGE_BITS+H)'(best_reg) * (RANGE_BITS+H)'(cr_reg[H-1:0]);
            pp_hi_reg <= (RANGE_BITS+CRW-H)'(best_reg) *
                         (RANGE_BITS+CRW-H)'(cr_reg[CRW-1:H]);
        end
        if (state_reg == ST_CMP2)
        begin
            // Quotient is below 2^15, so the top of the dividend is already below cr.
            rem_reg  <= num_reg >> 1;
            low_reg  <= {num_reg[0], {FRAC_BITS{1'b0}}};
            quot_reg <= '0;
        end
        if (state_reg == ST_DIV)
        begin
            low_reg <= low_reg << 1;
            if (trial >= {1'b0, cr_reg})
            begin
                rem_reg  <= CRW'(trial - {1'b0, cr_reg});
                quot_reg <= {quot_reg[QUOT_BITS-2:0], 1'b1};
                if (last_div)
                    best_reg <= {quot_reg[QUOT_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= CRW'(trial);
                quot_reg <= {quot_reg[QUOT_BITS-2:0], 1'b0};
                if (last_div)
                    best_reg <= {quot_reg[QUOT_BITS-2:0], 1'b0};
            end
        end
        if (done_fire)
        begin
            range_reg <= (clamp_lo > (RANGE_BITS+2)'(cfg.far_limit)) ?
                         cfg.far_limit : RANGE_BITS'(clamp_lo);
            hit_reg   <= (best_reg < cfg.far_limit);
        end
    end

`ifndef SYNTHESIS
    a_best_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> (best_reg <= cfg.far_limit))
        else $error("nearest distance exceeds the upper range");
    a_wall_in_use: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ) |-> (k_reg < n_wall))
        else $error("wall read beyond the walls in use");
    a_div_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (div_cnt_reg < DIV_CNT_BITS'(QUOT_BITS)))
        else $error("divider ran past its quotient width");
    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> ($past(state_reg) == ST_DONE))
        else $error("result word raised outside the finishing state");
`endif

endmodule

// File: rtl/lidar_ray_cast_over_walls_unit.sv
// Top level of the lidar ray cast unit: configuration registers, front end and back end.
`timescale 1ns / 1ps
// A write word stores one wall in the back end; a cast word runs the direction CORDIC,
// then for each wall in use a table read, subtraction, multiplication and test, a
// comparison when the wall is hit in front of the origin, and a division when it is
// nearer than the best so far, then a clamp. A two-word queue lets the next word be
// accepted meanwhile, and a result register holds a finished range until it is taken.
module lidar_ray_cast_over_walls_unit #(
    parameter int MAX_WALLS  = 64,
    parameter int ANGLE_BITS = 12,
    parameter int COORD_BITS = 16
) (
    input  logic clk,
    input  logic rst_n,
    lrc_cmd_if.sink   cmd,
    lrc_res_if.source res,
    lrc_cfg_if.sink   cfg
);
    import lrc_pkg::*;

    lrc_cfg_t cfg_reg;

    lrc_cmd_if #(.COORD_BITS(COORD_BITS), .ANGLE_BITS(ANGLE_BITS)) queue_ch ();

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.wall_count <= WALL_COUNT_RESET;
            cfg_reg.near_limit <= NEAR_LIMIT_RESET;
            cfg_reg.far_limit  <= FAR_LIMIT_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_WALL_COUNT: cfg_reg.wall_count <= cfg.data[COUNT_BITS-1:0];
                REG_NEAR_LIMIT: cfg_reg.near_limit <= cfg.data;
                REG_FAR_LIMIT:  cfg_reg.far_limit  <= cfg.data;
                default:        cfg_reg            <= cfg_reg;
            endcase
        end
    end

    lrc_front #(
        .MAX_WALLS  (MAX_WALLS),
        .COORD_BITS (COORD_BITS),
        .ANGLE_BITS (ANGLE_BITS)
    ) u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .q_out (queue_ch)
    );

    lrc_back #(
        .MAX_WALLS  (MAX_WALLS),
        .COORD_BITS (COORD_BITS),
        .ANGLE_BITS (ANGLE_BITS)
    ) u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .q_in  (queue_ch),
        .res   (res),
        .cfg   (cfg_reg)
    );

endmodule
